/* rtl/lif_pkg.sv */
`timescale 1ns / 1ps

package lif_pkg;

   localparam int FRAC_BITS = 16;
   localparam int DATA_W    = 32;
   localparam int UNS_W     = 31;
   localparam int MUL_W     = DATA_W + 1;
   localparam int PROD_W    = 2 * MUL_W;
   localparam int RC_W      = 2 * UNS_W - FRAC_BITS;
   localparam int DIV_W     = DATA_W + FRAC_BITS;
   localparam int DIV_CNT_W = $clog2(DIV_W);
   localparam int CSR_IDX_W = 3;

   // register reset values, raw Q16.16 patterns
   localparam logic signed [DATA_W-1:0] REST_RST   = -32'sd4259840;
   localparam logic signed [DATA_W-1:0] RESET_RST  = -32'sd4587520;
   localparam logic signed [DATA_W-1:0] THRESH_RST = -32'sd3276800;
   localparam logic [UNS_W-1:0]         RES_RST    = 31'd655360;
   localparam logic [UNS_W-1:0]         CAP_RST    = 31'd65536;
   localparam logic [UNS_W-1:0]         REFR_RST   = 31'd131072;
   localparam logic [UNS_W-1:0]         STEP_RST   = 31'd6554;

   // -1.0 in fixed point: no spike yet
   localparam logic signed [DATA_W-1:0] SPIKE_NONE =
      ~((DATA_W'(1) << FRAC_BITS) - DATA_W'(1));

   typedef enum logic {
      ITEM_INJECT = 1'b0,
      ITEM_STEP   = 1'b1
   } item_kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_REST   = 3'd0,
      CSR_RESET  = 3'd1,
      CSR_THRESH = 3'd2,
      CSR_RES    = 3'd3,
      CSR_CAP    = 3'd4,
      CSR_REFR   = 3'd5,
      CSR_STEP   = 3'd6
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TIME,
      ST_MUL_RI,
      ST_NUM,
      ST_RC,
      ST_DIV,
      ST_DV,
      ST_MUL_INC,
      ST_VOLT,
      ST_DONE
   } lif_state_type;

   typedef struct packed {
      item_kind_type            req_type;
      logic signed [DATA_W-1:0] current_in;
      logic signed [DATA_W-1:0] time_stamp;
   } lif_req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] potential;
      logic                     spiked;
      logic signed [DATA_W-1:0] last_spike_time;
   } lif_rsp_type;

endpackage

/* rtl/lif_neuron_update_unit.sv */
`timescale 1ns / 1ps

// Channel  Direction  Handshake                 Payload
// req      in         req_valid / req_ready     req_data (lif_req_type)
// rsp      out        rsp_valid / rsp_ready     rsp_data (lif_rsp_type)
// csr      in         csr_valid / csr_ready     csr_index, csr_wdata
//
// Inject beat: IDLE, then DONE. Step beat inside the refractory window: IDLE,
// TIME, then DONE. Full step runs through MUL_RI, NUM, RC, DIV, DV, MUL_INC,
// VOLT and DONE; the restoring divider for dV / RC retires one quotient bit per cycle.
// One 33x33 signed multiplier is shared by R*I, R*C and dv*dt.
// Synchronous reset loads register defaults and neuron rest state; csr is
// always ready. The result sits in an output register; a stalled rsp
// holds the sequencer in its last state until the beat is taken.

module lif_neuron_update_unit
   import lif_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_ready,
   input  lif_req_type          req_data,

   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output lif_rsp_type          rsp_data,

   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_wdata
);

   // signed saturate to 32 bits
   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
      logic signed [PROD_W-1:0] hi;
      logic signed [PROD_W-1:0] lo;
      logic signed [DATA_W-1:0] r;
      hi = $signed({{(PROD_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}});
      lo = $signed({{(PROD_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}});
      if (v > hi) begin
         r = $signed({1'b0, {(DATA_W-1){1'b1}}});
      end else if (v < lo) begin
         r = $signed({1'b1, {(DATA_W-1){1'b0}}});
      end else begin
         r = v[DATA_W-1:0];
      end
      return r;
   endfunction

   // divide by 2^F, rounding toward zero
   function automatic logic signed [PROD_W-1:0] trunc_shift(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] bias;
      logic signed [PROD_W-1:0] t;
      bias = '0;
      if (p[PROD_W-1]) begin
         bias[FRAC_BITS-1:0] = '1;
      end
      t = p + bias;
      return t >>> FRAC_BITS;
   endfunction

   // sequencer
   lif_state_type state_ff, state_in;

   // configuration
   logic signed [DATA_W-1:0] rest_ff,   rest_in;
   logic signed [DATA_W-1:0] rpot_ff,   rpot_in;
   logic signed [DATA_W-1:0] thr_ff,    thr_in;
   logic [UNS_W-1:0]         res_ff,    res_in;
   logic [UNS_W-1:0]         cap_ff,    cap_in;
   logic [UNS_W-1:0]         refr_ff,   refr_in;
   logic [UNS_W-1:0]         step_ff,   step_in;

   // neuron state
   logic signed [DATA_W-1:0] volt_ff,   volt_in;
   logic signed [DATA_W-1:0] cur_ff,    cur_in;
   logic [UNS_W-1:0]         tss_ff,    tss_in;
   logic signed [DATA_W-1:0] spike_ff,  spike_in;
   logic                     check_ff,  check_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   // working registers
   lif_req_type              req_ff,    req_in;
   logic signed [PROD_W-1:0] prod_ff,   prod_in;
   logic signed [DATA_W-1:0] num_ff,    num_in;
   logic [RC_W-1:0]          rc_ff,     rc_in;
   logic [RC_W-1:0]          rem_ff,    rem_in;
   logic [DIV_W-1:0]         quo_ff,    quo_in;
   logic [DIV_CNT_W-1:0]     cnt_ff,    cnt_in;
   logic signed [DATA_W-1:0] dv_ff,     dv_in;
   lif_rsp_type              rsp_ff,    rsp_in;

   // shared multiplier
   logic signed [MUL_W-1:0]  mul_a;
   logic signed [MUL_W-1:0]  mul_b;
   logic signed [PROD_W-1:0] prod;
   logic                     mul_en;

   logic                     out_free;
   logic                     load_rsp;
   logic                     req_fire;

   logic [DATA_W-1:0]        tss_sum;
   logic [UNS_W-1:0]         tss_sat;
   logic signed [PROD_W-1:0] num_sum;
   logic [RC_W-1:0]          rc_raw;
   logic [DATA_W-1:0]        num_mag;
   logic [RC_W:0]            cand;
   logic                     take;
   logic [RC_W:0]            diff;
   logic                     dv_over;
   logic signed [PROD_W-1:0] volt_sum;
   logic                     fire;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign prod      = mul_a * mul_b;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_data.req_type == ITEM_STEP) ? ST_TIME : ST_DONE;
            end
         end
         ST_TIME: begin
            state_in = (tss_sat < refr_ff) ? ST_DONE : ST_MUL_RI;
         end
         ST_MUL_RI:  state_in = ST_NUM;
         ST_NUM:     state_in = ST_RC;
         ST_RC:      state_in = ST_DIV;
         ST_DIV: begin
            if (cnt_ff == DIV_CNT_W'(DIV_W - 1)) begin
               state_in = ST_DV;
            end
         end
         ST_DV:      state_in = ST_MUL_INC;
         ST_MUL_INC: state_in = ST_VOLT;
         ST_VOLT:    state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:    state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs: handshake and multiplier operand select
   always_comb begin
      req_ready = 1'b0;
      load_rsp  = 1'b0;
      mul_en    = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      unique case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_MUL_RI: begin
            mul_en = 1'b1;
            mul_a  = $signed({2'b00, res_ff});
            mul_b  = MUL_W'(cur_ff);
         end
         ST_NUM: begin
            mul_en = 1'b1;
            mul_a  = $signed({2'b00, res_ff});
            mul_b  = $signed({2'b00, cap_ff});
         end
         ST_MUL_INC: begin
            mul_en = 1'b1;
            mul_a  = MUL_W'(dv_ff);
            mul_b  = $signed({2'b00, step_ff});
         end
         ST_DONE: load_rsp = out_free;
         default: ;
      endcase
   end

   // datapath
   always_comb begin
      rest_in      = rest_ff;
      rpot_in      = rpot_ff;
      thr_in       = thr_ff;
      res_in       = res_ff;
      cap_in       = cap_ff;
      refr_in      = refr_ff;
      step_in      = step_ff;
      volt_in      = volt_ff;
      cur_in       = cur_ff;
      tss_in       = tss_ff;
      spike_in     = spike_ff;
      check_in     = check_ff;
      rsp_valid_in = rsp_valid_ff;
      req_in       = req_ff;
      prod_in      = prod_ff;
      num_in       = num_ff;
      rc_in        = rc_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      dv_in        = dv_ff;
      rsp_in       = rsp_ff;

      // time since spike, saturating at 2^31 - 1
      tss_sum = {1'b0, tss_ff} + {1'b0, step_ff};
      tss_sat = tss_sum[DATA_W-1] ? '1 : tss_sum[UNS_W-1:0];

      num_sum = PROD_W'(rest_ff) - PROD_W'(volt_ff) + trunc_shift(prod_ff);

      rc_raw  = prod_ff[2*UNS_W-1:FRAC_BITS];

      num_mag = num_ff[DATA_W-1] ? DATA_W'(-num_ff) : DATA_W'(num_ff);

      // restoring divider step
      cand = {rem_ff, quo_ff[DIV_W-1]};
      take = (cand >= {1'b0, rc_ff});
      diff = cand - {1'b0, rc_ff};

      dv_over  = |quo_ff[DIV_W-1:DATA_W-1];

      volt_sum = PROD_W'(volt_ff) + trunc_shift(prod_ff);

      fire = check_ff && (volt_ff >= thr_ff);

      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_REST:   rest_in = $signed(csr_wdata);
            CSR_RESET:  rpot_in = $signed(csr_wdata);
            CSR_THRESH: thr_in  = $signed(csr_wdata);
            CSR_RES:    res_in  = csr_wdata[UNS_W-1:0];
            CSR_CAP:    cap_in  = csr_wdata[UNS_W-1:0];
            CSR_REFR:   refr_in = csr_wdata[UNS_W-1:0];
            CSR_STEP:   step_in = csr_wdata[UNS_W-1:0];
            default: ;
         endcase
      end

      if (mul_en) begin
         prod_in = prod;
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               req_in   = req_data;
               check_in = 1'b0;
               if (req_data.req_type == ITEM_INJECT) begin
                  cur_in = sat32(PROD_W'(cur_ff) + PROD_W'(req_data.current_in));
               end
            end
         end
         ST_TIME: tss_in = tss_sat;
         ST_NUM:  num_in = sat32(num_sum);
         ST_RC: begin
            rc_in  = (rc_raw == '0) ? RC_W'(1) : rc_raw;
            quo_in = {num_mag, {FRAC_BITS{1'b0}}};
            rem_in = '0;
            cnt_in = '0;
         end
         ST_DIV: begin
            rem_in = take ? diff[RC_W-1:0] : cand[RC_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], take};
            cnt_in = cnt_ff + DIV_CNT_W'(1);
         end
         ST_DV: begin
            if (num_ff[DATA_W-1]) begin
               dv_in = dv_over ? $signed({1'b1, {(DATA_W-1){1'b0}}})
                               : $signed(-quo_ff[DATA_W-1:0]);
            end else begin
               dv_in = dv_over ? $signed({1'b0, {(DATA_W-1){1'b1}}})
                               : $signed(quo_ff[DATA_W-1:0]);
            end
         end
         ST_VOLT: begin
            volt_in  = sat32(volt_sum);
            check_in = 1'b1;
         end
         ST_DONE: begin
            if (load_rsp) begin
               rsp_valid_in = 1'b1;
               rsp_in.spiked = fire;
               rsp_in.potential = fire ? rpot_ff : volt_ff;
               rsp_in.last_spike_time = fire ? req_ff.time_stamp : spike_ff;
               if (fire) begin
                  volt_in  = rpot_ff;
                  tss_in   = '0;
                  spike_in = req_ff.time_stamp;
               end
               // an Euler update consumes the accumulated current
               if (check_ff) begin
                  cur_in = '0;
               end
            end
         end
         default: ;
      endcase
   end

   // control, configuration and neuron state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rest_ff      <= REST_RST;
         rpot_ff      <= RESET_RST;
         thr_ff       <= THRESH_RST;
         res_ff       <= RES_RST;
         cap_ff       <= CAP_RST;
         refr_ff      <= REFR_RST;
         step_ff      <= STEP_RST;
         volt_ff      <= REST_RST;
         cur_ff       <= '0;
         tss_ff       <= REFR_RST;
         spike_ff     <= SPIKE_NONE;
         check_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rest_ff      <= rest_in;
         rpot_ff      <= rpot_in;
         thr_ff       <= thr_in;
         res_ff       <= res_in;
         cap_ff       <= cap_in;
         refr_ff      <= refr_in;
         step_ff      <= step_in;
         volt_ff      <= volt_in;
         cur_ff       <= cur_in;
         tss_ff       <= tss_in;
         spike_ff     <= spike_in;
         check_ff     <= check_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working payload registers
   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      prod_ff <= prod_in;
      num_ff  <= num_in;
      rc_ff   <= rc_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      cnt_ff  <= cnt_in;
      dv_ff   <= dv_in;
      rsp_ff  <= rsp_in;
   end

endmodule
